### rtl/core/hlc_pkg.sv
// hybrid logical clock package: field widths, register indexes, reset values
// no dependencies; imported by hybrid_logical_clock_top
package hlc_pkg;

   localparam int LOGICAL_BITS_DEF = 12;
   localparam int PHYS_BITS_DEF    = 52;

   localparam int USEC_W = 52;
   localparam int TIME_W = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [USEC_W-1:0] USEC_MAX = {USEC_W{1'b1}};

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SKEW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRASH_BOUND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_ON     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_ON  = 2'd3;

   localparam logic [USEC_W-1:0] MAX_SKEW_RST    = 52'd500000;
   localparam logic [USEC_W-1:0] CRASH_BOUND_RST = 52'd60000000;

   // item kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_MERGE = 1'b1;

endpackage

### rtl/core/hybrid_logical_clock_top.sv
// hybrid logical clock, top level: input word register, single-pass update, result register
// depends on hlc_pkg
//
// usage
//   req_* carries one word: a read (kind 0) with physical time and its error bound, or a
//   merge (kind 1) with a packed peer time. a word is taken when req_valid is high and
//   req_stall is low. a read returns one rsp_* word; a merge returns nothing and only
//   moves the clock forward when the peer time (plus one logical tick) is later.
//   csr_* writes the skew limits and flags; csr_ready is always high, writes are meant
//   to land only while no word is in flight.
//   a read word passes the input register, then the result register. throughput: one word
//   per cycle while no rsp_stall holds a read in the input register, set by the
//   combinational compare/increment/subtract path between the two registers.
//   stall: when rsp_stall holds a result, a pending read waits in the input register
//   and req_stall rises; merge words keep flowing since they need no result slot.
//   reset: clock state goes to zero, skew registers to their defaults, both
//   pipeline registers empty.
module hybrid_logical_clock_top
   import hlc_pkg::*;
#(
   parameter int LOGICAL_BITS = LOGICAL_BITS_DEF,
   parameter int PHYS_BITS    = PHYS_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [USEC_W-1:0]    req_phys_now_usec,
   input  logic [USEC_W-1:0]    req_phys_error_usec,
   input  logic [TIME_W-1:0]    req_peer_time,
   input  logic                 req_peer_valid,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [TIME_W-1:0]    rsp_stamp,
   output logic [USEC_W-1:0]    rsp_error_usec,
   output logic [USEC_W-1:0]    rsp_skew_usec,
   output logic                 rsp_skew_fatal,
   output logic                 rsp_skew_warning,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [USEC_W-1:0]    csr_data
);

   localparam int LB = LOGICAL_BITS;
   localparam int PB = PHYS_BITS;
   // compare width wide enough for both stored micros and 52-bit fields
   localparam int NW = (PB > USEC_W) ? PB : USEC_W;
   localparam int SW = NW + 1;

   // configuration registers
   logic [USEC_W-1:0] max_skew_ff;
   logic [USEC_W-1:0] crash_bound_ff;
   logic              fail_on_ff;
   logic              control_on_ff;

   // clock state
   logic [PB-1:0] last_micros_ff, last_micros_in;
   logic [LB-1:0] logical_ff, logical_in;

   // input word register
   logic              s1_v_ff, s1_v_in;
   logic              s1_kind_ff;
   logic [USEC_W-1:0] s1_now_ff;
   logic [USEC_W-1:0] s1_err_ff;
   logic [TIME_W-1:0] s1_peer_ff;
   logic              s1_pvalid_ff;

   // result register
   logic              rsp_v_ff, rsp_v_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic [USEC_W-1:0] rsp_err_ff, rsp_err_in;
   logic [USEC_W-1:0] rsp_skew_ff, rsp_skew_in;
   logic              rsp_fatal_ff, rsp_fatal_in;
   logic              rsp_warn_ff, rsp_warn_in;

   logic req_take;
   logic out_free;
   logic adv;

   // read path
   logic [PB-1:0] now_p;
   logic          ahead;
   logic [PB-1:0] skew_p;
   logic [NW-1:0] skew_w;
   logic          over_max;
   logic          hard;
   logic          fatal;
   logic          warn;
   logic          l_wrap;
   logic [LB-1:0] rd_l;
   logic [PB-1:0] rd_m;
   logic [PB-1:0] diff_p;
   logic [SW-1:0] e_sum;
   logic          e_sat;

   // merge path
   logic [PB-1:0] pm_raw;
   logic [LB-1:0] pl_raw;
   logic          p_wrap;
   logic [PB-1:0] pm;
   logic [LB-1:0] pl;
   logic          peer_later;

   assign csr_ready = 1'b1;

   // a read needs the result slot; a merge leaves at once
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign adv       = s1_v_ff && ((s1_kind_ff == KIND_MERGE) || out_free);
   assign req_stall = s1_v_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   // read: jump ahead or tick the logical counter
   assign now_p    = PB'(s1_now_ff);
   assign ahead    = now_p > last_micros_ff;
   assign skew_p   = (now_p < last_micros_ff) ? (last_micros_ff - now_p) : '0;
   assign skew_w   = NW'(skew_p);
   assign over_max = skew_w > NW'(max_skew_ff);
   assign hard     = fail_on_ff || ((crash_bound_ff != '0) && (skew_w > NW'(crash_bound_ff)));
   assign fatal    = over_max && hard && control_on_ff;
   assign warn     = over_max && !(hard && control_on_ff);

   assign l_wrap = &logical_ff;
   assign rd_l   = logical_ff + LB'(1);
   assign rd_m   = l_wrap ? (last_micros_ff + PB'(1)) : last_micros_ff;

   // widened error: distance from physical now plus its own bound, saturated
   assign diff_p = (rd_m >= now_p) ? (rd_m - now_p) : '0;
   assign e_sum  = SW'(diff_p) + SW'(s1_err_ff);
   assign e_sat  = (SW'(diff_p) > SW'(USEC_MAX)) || (e_sum > SW'(USEC_MAX));

   // merge: peer time plus one logical tick, kept if lexicographically later
   assign pm_raw     = PB'(s1_peer_ff >> LB);
   assign pl_raw     = s1_peer_ff[LB-1:0];
   assign p_wrap     = &pl_raw;
   assign pl         = pl_raw + LB'(1);
   assign pm         = p_wrap ? (pm_raw + PB'(1)) : pm_raw;
   assign peer_later = (last_micros_ff < pm) || ((last_micros_ff == pm) && (logical_ff < pl));

   always_comb begin
      last_micros_in = last_micros_ff;
      logical_in     = logical_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_skew_in    = rsp_skew_ff;
      rsp_fatal_in   = rsp_fatal_ff;
      rsp_warn_in    = rsp_warn_ff;
      rsp_v_in       = rsp_v_ff && rsp_stall;

      if (adv) begin
         case (s1_kind_ff)
            KIND_MERGE: begin
               if (s1_pvalid_ff && peer_later) begin
                  last_micros_in = pm;
                  logical_in     = pl;
               end
            end
            KIND_READ: begin
               rsp_v_in = 1'b1;
               if (ahead) begin
                  last_micros_in = now_p;
                  logical_in     = LB'(1);
                  rsp_time_in    = TIME_W'({now_p, LB'(0)});
                  rsp_err_in     = s1_err_ff;
                  rsp_skew_in    = '0;
                  rsp_fatal_in   = 1'b0;
                  rsp_warn_in    = 1'b0;
               end else begin
                  last_micros_in = rd_m;
                  logical_in     = rd_l;
                  rsp_time_in    = TIME_W'({rd_m, rd_l}) - TIME_W'(1);
                  rsp_err_in     = e_sat ? USEC_MAX : e_sum[USEC_W-1:0];
                  rsp_skew_in    = (skew_w > NW'(USEC_MAX)) ? USEC_MAX : skew_w[USEC_W-1:0];
                  rsp_fatal_in   = fatal;
                  rsp_warn_in    = warn;
               end
            end
            default: begin
               rsp_v_in = rsp_v_ff && rsp_stall;
            end
         endcase
      end
   end

   always_comb begin
      s1_v_in = s1_v_ff && !adv;
      if (req_take) begin
         s1_v_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff        <= 1'b0;
         rsp_v_ff       <= 1'b0;
         last_micros_ff <= '0;
         logical_ff     <= '0;
      end else begin
         s1_v_ff        <= s1_v_in;
         rsp_v_ff       <= rsp_v_in;
         last_micros_ff <= last_micros_in;
         logical_ff     <= logical_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_skew_ff    <= MAX_SKEW_RST;
         crash_bound_ff <= CRASH_BOUND_RST;
         fail_on_ff     <= 1'b1;
         control_on_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_SKEW:    max_skew_ff    <= csr_data;
            CSR_CRASH_BOUND: crash_bound_ff <= csr_data;
            CSR_FAIL_ON:     fail_on_ff     <= csr_data[0];
            CSR_CONTROL_ON:  control_on_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff   <= req_kind;
         s1_now_ff    <= req_phys_now_usec;
         s1_err_ff    <= req_phys_error_usec;
         s1_peer_ff   <= req_peer_time;
         s1_pvalid_ff <= req_peer_valid;
      end
      rsp_time_ff  <= rsp_time_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_skew_ff  <= rsp_skew_in;
      rsp_fatal_ff <= rsp_fatal_in;
      rsp_warn_ff  <= rsp_warn_in;
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_stamp        = rsp_time_ff;
   assign rsp_error_usec   = rsp_err_ff;
   assign rsp_skew_usec    = rsp_skew_ff;
   assign rsp_skew_fatal   = rsp_fatal_ff;
   assign rsp_skew_warning = rsp_warn_ff;

   // a stall toward the sender only comes from a held word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_v_ff)
      else $error("req_stall raised with empty input register");

   // every read that leaves the input register shows up as a result
   a_read_gives_word: assert property (@(posedge clock) disable iff (reset)
      (adv && (s1_kind_ff == KIND_READ)) |=> rsp_v_ff)
      else $error("read word lost between registers");

   // clock state moves only when a word is processed
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(last_micros_ff) && $stable(logical_ff)))
      else $error("clock state changed without a word");

   // warning and fatal never both set
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> !(rsp_fatal_ff && rsp_warn_ff))
      else $error("skew fatal and warning both set");

endmodule

### tb/hlc_checker.sv
`timescale 1ns / 1ps
// hybrid logical clock checker: follows the req, rsp and csr channels, predicts each
// read word and compares it field by field; depends on hlc_pkg
module hlc_checker
   import hlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_kind,
   input  logic [USEC_W-1:0]    req_phys_now_usec,
   input  logic [USEC_W-1:0]    req_phys_error_usec,
   input  logic [TIME_W-1:0]    req_peer_time,
   input  logic                 req_peer_valid,

   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [TIME_W-1:0]    rsp_stamp,
   input  logic [USEC_W-1:0]    rsp_error_usec,
   input  logic [USEC_W-1:0]    rsp_skew_usec,
   input  logic                 rsp_skew_fatal,
   input  logic                 rsp_skew_warning,

   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [USEC_W-1:0]    csr_data,

   output int                   failures,
   output int                   outstanding
);

   localparam int LB = LOGICAL_BITS_DEF;
   localparam int PB = PHYS_BITS_DEF;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [USEC_W-1:0] error_usec;
      logic [USEC_W-1:0] skew_usec;
      logic              skew_fatal;
      logic              skew_warning;
   } reading_t;

   reading_t          pending_readings[$];
   int                fail_cnt;
   logic [USEC_W-1:0] max_skew;
   logic [USEC_W-1:0] crash_bound;
   logic              fail_on;
   logic              control_on;
   logic [PB-1:0]     last_micros;
   logic [LB-1:0]     logical_count;

   function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                       input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin : watch
      logic [PB-1:0]     now;
      logic [PB-1:0]     m;
      logic [LB:0]       l;
      logic [USEC_W:0]   err_sum;
      logic [USEC_W-1:0] skew;
      logic              hard;
      logic              over;
      reading_t          want;
      if (reset) begin
         pending_readings.delete();
         fail_cnt      = 0;
         max_skew      = MAX_SKEW_RST;
         crash_bound   = CRASH_BOUND_RST;
         fail_on       = 1'b1;
         control_on    = 1'b0;
         last_micros   = '0;
         logical_count = '0;
      end else begin
         // results first: a result at this edge always belongs to an older word
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               $error("result word with none expected: stamp %0h", rsp_stamp);
               fail_cnt++;
            end else begin
               want = pending_readings.pop_front();
               check_field("stamp", want.stamp, rsp_stamp);
               check_field("error_usec", want.error_usec, rsp_error_usec);
               check_field("skew_usec", want.skew_usec, rsp_skew_usec);
               check_field("skew_fatal", want.skew_fatal, rsp_skew_fatal);
               check_field("skew_warning", want.skew_warning, rsp_skew_warning);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_SKEW:    max_skew = csr_data;
               CSR_CRASH_BOUND: crash_bound = csr_data;
               CSR_FAIL_ON:     fail_on = csr_data[0];
               CSR_CONTROL_ON:  control_on = csr_data[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            if (req_kind == KIND_MERGE) begin
               if (req_peer_valid) begin
                  // peer time plus one tick, carry into the micros
                  m = req_peer_time[LB +: PB];
                  l = {1'b0, req_peer_time[LB-1:0]} + (LB+1)'(1);
                  if (l[LB])
                     m = m + PB'(1);
                  if (last_micros < m || (last_micros == m && logical_count < l[LB-1:0])) begin
                     last_micros   = m;
                     logical_count = l[LB-1:0];
                  end
               end
            end else begin
               now = req_phys_now_usec[PB-1:0];
               if (now > last_micros) begin
                  want.stamp        = {now, {LB{1'b0}}};
                  want.error_usec   = req_phys_error_usec;
                  want.skew_usec    = '0;
                  want.skew_fatal   = 1'b0;
                  want.skew_warning = 1'b0;
                  last_micros       = now;
                  logical_count     = LB'(1);
               end else begin
                  skew = last_micros - now;
                  over = skew > max_skew;
                  hard = fail_on || (crash_bound != '0 && skew > crash_bound);
                  m = last_micros;
                  l = {1'b0, logical_count} + (LB+1)'(1);
                  if (l[LB])
                     m = m + PB'(1);
                  last_micros   = m;
                  logical_count = l[LB-1:0];
                  // widened error, distance clamped at zero after a micros wrap
                  err_sum = ((m >= now) ? {1'b0, m - now} : {(USEC_W+1){1'b0}})
                            + {1'b0, req_phys_error_usec};
                  want.stamp        = {m, l[LB-1:0]} - TIME_W'(1);
                  want.error_usec   = err_sum[USEC_W] ? USEC_MAX : err_sum[USEC_W-1:0];
                  want.skew_usec    = skew;
                  want.skew_fatal   = over && hard && control_on;
                  want.skew_warning = over && !(hard && control_on);
               end
               pending_readings.push_back(want);
            end
         end
      end
      failures    <= fail_cnt;
      outstanding <= pending_readings.size();
   end

endmodule

### tb/hybrid_logical_clock_top_tb.sv
`timescale 1ns / 1ps
// testbench top for hybrid_logical_clock_top: makes read and merge words, csr writes
// and random backpressure, gives the verdict; depends on hlc_pkg and hlc_checker
module hybrid_logical_clock_top_tb;
   import hlc_pkg::*;

   localparam int LB = LOGICAL_BITS_DEF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind = KIND_READ;
   logic [USEC_W-1:0]    req_phys_now_usec = '0;
   logic [USEC_W-1:0]    req_phys_error_usec = '0;
   logic [TIME_W-1:0]    req_peer_time = '0;
   logic                 req_peer_valid = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [TIME_W-1:0]    rsp_stamp;
   logic [USEC_W-1:0]    rsp_error_usec;
   logic [USEC_W-1:0]    rsp_skew_usec;
   logic                 rsp_skew_fatal;
   logic                 rsp_skew_warning;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MAX_SKEW;
   logic [USEC_W-1:0]    csr_data = '0;

   int                   fail_count;
   int                   in_flight;

   // idling knobs, changed per phase: percent chance of a gap or a stall
   int                   req_gap_pct = 20;
   int                   rsp_stall_pct = 20;
   int                   stall_left = 0;

   // rough physical time that well-formed words are built around
   logic [USEC_W-1:0]    clock_base = '0;

   hybrid_logical_clock_top u_dut (.*);

   hlc_checker u_checker (.*, .failures(fail_count), .outstanding(in_flight));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far beyond the slowest legal run
   initial begin : watchdog
      #6_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side backpressure: mostly short stalls, now and then a long one
   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else
         rsp_stall <= 1'b0;
   end

   function automatic logic [USEC_W-1:0] rand_usec();
      return USEC_W'({$urandom, $urandom});
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   // error bounds: mostly small, sometimes the extremes or anything at all
   function automatic logic [USEC_W-1:0] pick_error();
      case ($urandom_range(9))
         0:       return USEC_MAX;
         1:       return rand_usec();
         2:       return '0;
         default: return USEC_W'($urandom_range(1000));
      endcase
   endfunction

   // present one word, hold it through stalls, then maybe leave a gap
   task automatic push_word(input logic kind, input logic [USEC_W-1:0] now,
                            input logic [USEC_W-1:0] err, input logic [TIME_W-1:0] peer,
                            input logic peer_ok);
      int idle;
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_phys_now_usec   <= now;
      req_phys_error_usec <= err;
      req_peer_time       <= peer;
      req_peer_valid      <= peer_ok;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      idle = 0;
      if ($urandom_range(99) < req_gap_pct)
         idle = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   // drain: every read answered, then a short wait for merges still in the pipe
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [USEC_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [USEC_W-1:0] max_skew, input logic [USEC_W-1:0] crash,
                            input logic [USEC_W-1:0] fail_on, input logic [USEC_W-1:0] ctrl_on);
      settle();
      write_reg(CSR_MAX_SKEW, max_skew);
      write_reg(CSR_CRASH_BOUND, crash);
      write_reg(CSR_FAIL_ON, fail_on);
      write_reg(CSR_CONTROL_ON, ctrl_on);
   endtask

   // random words: mostly a plausible clock history, some carry bursts, some noise
   task automatic run_phase(input int words);
      int                done;
      int                pick;
      int                burst;
      logic              kind;
      logic              peer_ok;
      logic [USEC_W-1:0] now;
      logic [USEC_W-1:0] back;
      logic [TIME_W-1:0] peer;
      logic [LB-1:0]     tick;
      done = 0;
      while (done < words) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // physical time creeps forward, now and then steps back across a limit
            clock_base = clock_base + USEC_W'($urandom_range(3));
            now = clock_base;
            if ($urandom_range(5) == 0) begin
               case ($urandom_range(4))
                  0:       back = USEC_W'($urandom_range(1, 200));
                  1:       back = USEC_W'($urandom_range(200, 5000));
                  2:       back = USEC_W'($urandom_range(499_900, 500_100));
                  3:       back = USEC_W'($urandom_range(59_999_900, 60_000_100));
                  default: back = USEC_W'($urandom);
               endcase
               now = (back > clock_base) ? '0 : clock_base - back;
            end
            push_word(KIND_READ, now, pick_error(), rand_time(), 1'($urandom_range(1)));
            done++;
         end else if (pick < 70) begin
            // peer close to our own time, logical count sometimes near the top
            tick = ($urandom_range(3) == 0) ? {{(LB-4){1'b1}}, 4'($urandom_range(15))}
                                            : LB'($urandom);
            peer = {clock_base + USEC_W'($urandom_range(4)) - USEC_W'(2), tick};
            push_word(KIND_MERGE, rand_usec(), rand_usec(), peer, 1'b1);
            done++;
         end else if (pick < 76) begin
            // invalid peer, must change nothing
            push_word(KIND_MERGE, rand_usec(), rand_usec(), rand_time(), 1'b0);
         end else if (pick < 86) begin
            // park the logical count near its top, then same-time reads force the carry
            peer = {clock_base, {(LB-4){1'b1}}, 4'($urandom_range(15))};
            push_word(KIND_MERGE, rand_usec(), rand_usec(), peer, 1'b1);
            burst = $urandom_range(4, 20);
            repeat (burst) push_word(KIND_READ, clock_base, pick_error(), rand_time(), 1'b0);
            done += burst + 1;
         end else begin
            // noise over the whole field ranges; keep the time base at the high mark
            kind    = 1'($urandom_range(1));
            now     = rand_usec();
            peer    = rand_time();
            peer_ok = 1'($urandom_range(1));
            push_word(kind, now, rand_usec(), peer, peer_ok);
            if (kind == KIND_READ) begin
               if (now > clock_base)
                  clock_base = now;
               done++;
            end else if (peer_ok) begin
               if (peer[TIME_W-1 -: USEC_W] > clock_base)
                  clock_base = peer[TIME_W-1 -: USEC_W];
               done++;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fatal reporting on, other registers at their reset values
      write_reg(CSR_CONTROL_ON, 52'd1);
      // equal time at zero, then the largest error bound
      push_word(KIND_READ, 52'd0, 52'd0, rand_time(), 1'b1);
      push_word(KIND_READ, 52'd0, USEC_MAX, rand_time(), 1'b0);
      // jump ahead, then equal, then a small step back with saturating error
      push_word(KIND_READ, 52'd1000, 52'd5, rand_time(), 1'b0);
      push_word(KIND_READ, 52'd1000, USEC_MAX, rand_time(), 1'b1);
      push_word(KIND_READ, 52'd900, USEC_MAX, rand_time(), 1'b0);
      // later peer merged, invalid peer ignored
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {52'd2_000_000, 12'd5}, 1'b1);
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {52'd3_000_000, 12'd0}, 1'b0);
      // backward skew past the limit with fail-on-skew set: fatal
      push_word(KIND_READ, 52'd1_000_000, 52'd7, rand_time(), 1'b1);
      // older peer ignored, peer at the logical top carries into the micros
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {52'd1_000_000, 12'd0}, 1'b1);
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {52'd2_000_000, 12'hFFF}, 1'b1);
      push_word(KIND_READ, 52'd2_000_001, 52'd1, rand_time(), 1'b0);
      // jump to the top of the micros range
      push_word(KIND_READ, USEC_MAX, USEC_MAX, rand_time(), 1'b1);

      // warning versus crash bound needs fail-on-skew cleared
      settle();
      write_reg(CSR_FAIL_ON, 52'd0);
      push_word(KIND_READ, USEC_MAX - 52'd1_000_000, 52'd0, rand_time(), 1'b0);
      push_word(KIND_READ, USEC_MAX - 52'd100_000_000, 52'd2, rand_time(), 1'b1);
      push_word(KIND_READ, USEC_MAX - 52'd10, 52'd0, rand_time(), 1'b0);
      // micros and logical both at the top: the read wraps to zero, time minus one is all ones
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {USEC_MAX, 12'hFFE}, 1'b1);
      push_word(KIND_READ, 52'd0, 52'd0, rand_time(), 1'b0);
      // peer that wraps on its carry is not later than zero
      push_word(KIND_MERGE, rand_usec(), rand_usec(), {USEC_MAX, 12'hFFF}, 1'b1);

      // random phases, each under its own register setting and idling mix
      clock_base = '0;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               configure(52'd100, 52'd1000, 52'd0, 52'd1);
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               configure(52'd0, 52'd0, 52'd1, 52'd1);
               req_gap_pct = 30;
               rsp_stall_pct = 30;
            end
            2: begin
               configure(USEC_MAX, USEC_MAX, 52'd0, 52'd0);
               req_gap_pct = 60;
               rsp_stall_pct = 10;
            end
            3: begin
               configure(52'd50, 52'd0, 52'd0, 52'd1);
               req_gap_pct = 10;
               rsp_stall_pct = 60;
            end
            4: begin
               configure(USEC_W'($urandom_range(300)), USEC_W'($urandom_range(3000)),
                         52'd1, 52'd0);
               req_gap_pct = 0;
               rsp_stall_pct = 50;
            end
            5: begin
               // every register gets random data here
               configure(rand_usec(), rand_usec(), rand_usec(), rand_usec());
               req_gap_pct = 50;
               rsp_stall_pct = 0;
            end
            default: begin
               configure(MAX_SKEW_RST, CRASH_BOUND_RST, 52'd1, 52'd0);
               req_gap_pct = 25;
               rsp_stall_pct = 25;
            end
         endcase
         run_phase(205);
      end

      settle();
      if (fail_count == 0 && in_flight == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
